FILE: hdl/rcw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Reno congestion window block.
// Used by rcw_divider, rcw_core and reno_congestion_window.
package rcw_pkg;

  localparam int WORD_W = 32;
  // dividend of the additive increase: counter plus acks, one bit wider
  localparam int DIVIDEND_W = WORD_W + 1;
  // window plus one plus quotient
  localparam int WIN_W = WORD_W + 2;
  localparam int DIV_STEPS = DIVIDEND_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [1:0] ACT_ACK  = 2'd0;
  localparam logic [1:0] ACT_LOSS = 2'd1;
  localparam logic [1:0] ACT_UNDO = 2'd2;
  localparam logic [1:0] ACT_LOAD = 2'd3;

  localparam logic [WORD_W-1:0] CWND_RESET  = 32'd10;
  localparam logic [WORD_W-1:0] SSTH_RESET  = 32'd2147483647;
  localparam logic [WORD_W-1:0] CLAMP_RESET = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] MIN_THRESH  = 32'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [WORD_W-1:0] acked;
    logic              cwnd_limited;
    logic [WORD_W-1:0] load_window;
    logic [WORD_W-1:0] load_threshold;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] window;
    logic [WORD_W-1:0] threshold;
    logic [WORD_W-1:0] answer;
  } result_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [WORD_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [WORD_W-1:0]     remainder;
  } div_rsp_t;

endpackage

FILE: hdl/reno_congestion_window.sv
`timescale 1ns / 1ps
// Reno congestion window: config register and output register around
// rcw_core, which captures the input. Depends on rcw_pkg, rcw_core.
//
//  channel  | handshake             | beat
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_stall   | action, acked, cwnd_limited, load_*
//  out      | out_valid / out_stall | window, threshold, answer
//  cfg      | cfg_valid / cfg_ready | window_clamp
//
// Loss, undo, load and ignored acks go through the execute and done states;
// acks that reach additive increase also pass the add and divide states, where
// the bit-serial divider works through the 33-bit counter sum.
// Reset: window 10, counter 0, threshold 2147483647, clamp all ones.
// in_stall is high while an item is in work; a result waiting in the output
// register does not hold off the next beat, only its completion.
module reno_congestion_window (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 action,
  input  logic [rcw_pkg::WORD_W-1:0] acked,
  input  logic                       cwnd_limited,
  input  logic [rcw_pkg::WORD_W-1:0] load_window,
  input  logic [rcw_pkg::WORD_W-1:0] load_threshold,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rcw_pkg::WORD_W-1:0] window,
  output logic [rcw_pkg::WORD_W-1:0] threshold,
  output logic [rcw_pkg::WORD_W-1:0] answer,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rcw_pkg::WORD_W-1:0] window_clamp
);
  import rcw_pkg::*;

  logic [WORD_W-1:0] clamp;
  item_t             item;
  logic              busy;
  logic              res_valid;
  logic              res_ready;
  result_t           res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clamp <= CLAMP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      clamp <= window_clamp;
    end
  end

  assign item.action         = action;
  assign item.acked          = acked;
  assign item.cwnd_limited   = cwnd_limited;
  assign item.load_window    = load_window;
  assign item.load_threshold = load_threshold;

  assign in_stall  = busy;
  assign res_ready = !out_valid || !out_stall;

  rcw_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid && !in_stall),
    .item      (item),
    .clamp     (clamp),
    .busy      (busy),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid <= 1'b1;
        window    <= res.window;
        threshold <= res.threshold;
        answer    <= res.answer;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/rcw_divider.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider: the dividend shifts out MSB first while
// quotient bits shift in, one bit per cycle. Depends on rcw_pkg.
module rcw_divider (
  input  logic              clk,
  input  logic              rst,
  input  rcw_pkg::div_req_t req,
  output rcw_pkg::div_rsp_t rsp
);
  import rcw_pkg::*;

  logic [DIVIDEND_W-1:0] quo;
  logic [WORD_W-1:0]     rem;
  logic [WORD_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0]  count;
  logic                  done;

  logic [DIVIDEND_W-1:0] trial;
  logic [DIVIDEND_W-1:0] diff;
  logic                  fits;

  always_comb begin
    trial = {rem, quo[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quo   <= req.dividend;
        rem   <= '0;
        dvs   <= req.divisor;
        count <= DIV_CNT_W'(DIV_STEPS);
      end else if (count != '0) begin
        // remainder stays below the divisor, so WORD_W bits hold it
        rem   <= fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
        quo   <= {quo[DIVIDEND_W-2:0], fits};
        count <= count - DIV_CNT_W'(1);
        done  <= (count == DIV_CNT_W'(1));
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

FILE: hdl/rcw_core.sv
`timescale 1ns / 1ps
// Window state and event sequencer: slow start, additive increase through
// the serial divider, loss, undo and load. Depends on rcw_pkg, rcw_divider.
module rcw_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  rcw_pkg::item_t                 item,
  input  logic [rcw_pkg::WORD_W-1:0]     clamp,
  output logic                           busy,
  output logic                           res_valid,
  input  logic                           res_ready,
  output rcw_pkg::result_t               res
);
  import rcw_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state;
  logic [WORD_W-1:0] cwnd;
  logic [WORD_W-1:0] cnt;
  logic [WORD_W-1:0] ssth;
  item_t             item_r;
  logic [WORD_W-1:0] answer;
  logic [WORD_W-1:0] acked_r;
  logic [WIN_W-1:0]  win_r;
  logic [WORD_W-1:0] divisor_r;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // slow start
  logic [WORD_W:0]   ss_sum;
  logic [WORD_W:0]   ss_over;
  logic              ss_below;
  logic [WORD_W-1:0] ss_target;
  logic [WORD_W-1:0] ss_left;
  logic [WORD_W-1:0] ss_win;
  // loss / undo
  logic [WORD_W-1:0] half;
  logic [WORD_W-1:0] loss_ans;
  logic [WORD_W-1:0] dbl;
  logic [WORD_W-1:0] undo_ans;
  // additive increase
  logic [WORD_W-1:0]     wdiv;
  logic                  ai_wrap;
  logic [WORD_W-1:0]     ai_cnt0;
  logic [WIN_W-1:0]      ai_win;
  logic [DIVIDEND_W-1:0] ai_div;
  logic [WIN_W-1:0]      fin_win;
  logic [WORD_W-1:0]     fin_cwnd;

  rcw_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    ss_sum    = {1'b0, cwnd} + {1'b0, item_r.acked};
    ss_over   = ss_sum - {1'b0, ssth};
    ss_below  = ss_sum < {1'b0, ssth};
    ss_target = ss_below ? ss_sum[WORD_W-1:0] : ssth;
    ss_left   = ss_below ? '0 : ss_over[WORD_W-1:0];
    ss_win    = (ss_target > clamp) ? clamp : ss_target;

    half     = {1'b0, cwnd[WORD_W-1:1]};
    loss_ans = (half > MIN_THRESH) ? half : MIN_THRESH;
    dbl      = {ssth[WORD_W-2:0], 1'b0};
    undo_ans = (cwnd > dbl) ? cwnd : dbl;

    // a zero window divides as one
    wdiv    = (cwnd == '0) ? WORD_W'(1) : cwnd;
    ai_wrap = cnt >= wdiv;
    ai_cnt0 = ai_wrap ? '0 : cnt;
    ai_win  = {2'b0, cwnd} + {{(WIN_W-1){1'b0}}, ai_wrap};
    ai_div  = {1'b0, ai_cnt0} + {1'b0, acked_r};

    fin_win  = win_r + {1'b0, div_rsp.quotient};
    fin_cwnd = (fin_win > {2'b0, clamp}) ? clamp : fin_win[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cwnd          <= CWND_RESET;
      cnt           <= '0;
      ssth          <= SSTH_RESET;
      div_req.start <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            item_r <= item;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          answer <= '0;
          case (item_r.action)
            ACT_ACK: begin
              if (!item_r.cwnd_limited) begin
                state <= S_DONE;
              end else if (cwnd < ssth) begin
                cwnd    <= ss_win;
                acked_r <= ss_left;
                state   <= (ss_left == '0) ? S_DONE : S_ADD;
              end else begin
                acked_r <= item_r.acked;
                state   <= S_ADD;
              end
            end
            ACT_LOSS: begin
              ssth   <= loss_ans;
              answer <= loss_ans;
              state  <= S_DONE;
            end
            ACT_UNDO: begin
              answer <= undo_ans;
              state  <= S_DONE;
            end
            default: begin
              cwnd  <= item_r.load_window;
              ssth  <= item_r.load_threshold;
              state <= S_DONE;
            end
          endcase
        end
        S_ADD: begin
          // always divide; a quotient of zero leaves the sum as the counter
          div_req.start    <= 1'b1;
          div_req.dividend <= ai_div;
          div_req.divisor  <= wdiv;
          divisor_r        <= wdiv;
          win_r            <= ai_win;
          state            <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            cwnd  <= fin_cwnd;
            cnt   <= div_rsp.remainder;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state != S_IDLE);
  assign res_valid     = (state == S_DONE);
  assign res.window    = cwnd;
  assign res.threshold = ssth;
  assign res.answer    = answer;

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_rsp.done) |-> div_rsp.remainder < divisor_r)
    else $error("remainder not below the window");

  a_loss_floor: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && item_r.action == ACT_LOSS) |=> ssth >= MIN_THRESH)
    else $error("threshold below floor after loss");

  a_clamped: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_rsp.done) |=> cwnd <= $past(clamp))
    else $error("window above clamp after increase");

endmodule
